>>> rtl/core/fdqm_pkg.sv
// Shared types, codes and helpers for the frame descriptor queue merge block.
// Used by fdqm_ctrl, fdqm_dpath and frame_descriptor_queue_merge.
package fdqm_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned AvgFracDef    = 8;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_DEQ   = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Delay value that marks a frame as never expiring
  localparam logic [15:0] INF_DELAY = 16'hffff;

  // Stored frame descriptor
  typedef struct packed {
    logic [11:0] handle;
    logic [10:0] octets;
    logic        inf;
    logic [31:0] recv;
    logic [31:0] expiry;
  } desc_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the incoming word, restart walk counters
    logic commit;    // finish the operation and load the result word
    logic mrg_step;  // move one merged entry into the merge buffer
    logic cpy_step;  // copy one merge buffer entry back into the first queue
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic walk;      // latched merge has entries to move and does not overflow
    logic mrg_last;  // one entry left to merge
    logic cpy_last;  // one entry left to copy back
    logic out_free;  // result register can take a new word
  } sts_t;

  // a is later than b in wrapped 32-bit time
  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 32'd0) && !diff[31];
  endfunction

endpackage

>>> rtl/core/fdqm_ctrl.sv
// Controller state machine for the frame descriptor queue merge block.
// Depends on fdqm_pkg for the command and status structs.
module fdqm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fdqm_pkg::sts_t sts_i,
  output fdqm_pkg::cmd_t cmd_o
);
  import fdqm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MRD  = 3'd2;
  localparam logic [2:0] S_MWR  = 3'd3;
  localparam logic [2:0] S_CRD  = 3'd4;
  localparam logic [2:0] S_CWR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  // Sequence each operation
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.walk) begin
          state_d = S_MRD;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      // Wait for the head reads of both queues
      S_MRD: state_d = S_MWR;
      S_MWR: begin
        cmd_o.mrg_step = 1'b1;
        state_d        = sts_i.mrg_last ? S_CRD : S_MRD;
      end
      // Wait for the merge buffer read
      S_CRD: state_d = S_CWR;
      S_CWR: begin
        cmd_o.cpy_step = 1'b1;
        state_d        = sts_i.cpy_last ? S_FIN : S_CRD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/fdqm_dpath.sv
// Datapath of the frame descriptor queue merge block: queue memories, merge
// buffer, pointers, totals, delay average and result register. Uses fdqm_pkg.
module fdqm_dpath #(
  parameter int unsigned QUEUE_DEPTH       = fdqm_pkg::QueueDepthDef,
  parameter int unsigned AVG_FRACTION_BITS = fdqm_pkg::AvgFracDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fdqm_pkg::cmd_t cmd_i,
  output fdqm_pkg::sts_t sts_o,
  input  logic [1:0]     mode_i,
  input  logic           sel_i,
  input  logic [31:0]    now_i,
  input  logic [11:0]    handle_i,
  input  logic [10:0]    octets_i,
  input  logic [15:0]    pdu_i,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [1:0]     status_o,
  output logic [11:0]    handle_o,
  output logic [10:0]    octets_o,
  output logic [31:0]    life_o,
  output logic           expired_o,
  output logic [6:0]     count_o,
  output logic [16:0]    qoctets_o,
  output logic [31:0]    avg_o,
  output logic [6:0]     dropped_o
);
  import fdqm_pkg::*;

  localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW  = 11 + CW;
  localparam int unsigned AVW = 32 + AVG_FRACTION_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  // Latched input word and register
  logic [1:0]  mode_q;
  logic        sel_q;
  logic [31:0] now_q;
  logic [11:0] handle_q;
  logic [10:0] octets_q;
  logic [15:0] pdu_q;
  logic [15:0] forced_q;

  // Queue control
  logic [AW-1:0] head_q [2];
  logic [AW-1:0] head_d [2];
  logic [AW-1:0] tail_q [2];
  logic [AW-1:0] tail_d [2];
  logic [CW-1:0] cnt_q  [2];
  logic [CW-1:0] cnt_d  [2];
  logic [OW-1:0] oct_q  [2];
  logic [OW-1:0] oct_d  [2];
  logic [AVW-1:0] avg_q, avg_d;
  logic [CW-1:0] n_q, n_d, i_q, i_d;

  // Memories and their registered read data
  desc_t q0_mem [QUEUE_DEPTH];
  desc_t q1_mem [QUEUE_DEPTH];
  desc_t mb_mem [QUEUE_DEPTH];
  desc_t rd0_q, rd1_q, mbrd_q;

  // Result word
  logic        out_valid_q;
  logic [1:0]  status_q, res_status;
  logic [11:0] handle_out_q, res_handle;
  logic [10:0] octets_out_q, res_octets;
  logic [31:0] life_q, res_life;
  logic        exp_q, res_exp;
  logic [6:0]  count_q, dropped_q, res_dropped;
  logic [16:0] qoct_q;
  logic [31:0] avg_out_q;
  logic        rq;

  // Enqueue descriptor and helpers
  logic [15:0]     delay;
  logic [31:0]     delay_w;
  desc_t           enq_desc, deq_desc, pick;
  logic            pick_second;
  logic [AVW:0]    avg_sum;
  logic            ovf;
  logic            full_sel, empty_sel;
  logic [CW:0]     tot_cnt;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign delay   = (forced_q != 16'd0) ? forced_q : pdu_q;
  assign delay_w = {16'd0, delay};
  always_comb begin
    enq_desc.handle = handle_q;
    enq_desc.octets = octets_q;
    enq_desc.inf    = (delay == INF_DELAY);
    enq_desc.recv   = now_q;
    enq_desc.expiry = enq_desc.inf ? 32'd0 : now_q + (delay_w << 3) + (delay_w << 1);
  end

  assign deq_desc  = sel_q ? rd1_q : rd0_q;
  assign full_sel  = (sel_q ? cnt_q[1] : cnt_q[0]) == DEPTH_C;
  assign empty_sel = (sel_q ? cnt_q[1] : cnt_q[0]) == '0;
  assign tot_cnt   = (CW+1)'(cnt_q[0]) + (CW+1)'(cnt_q[1]);
  assign ovf       = tot_cnt > (CW+1)'(QUEUE_DEPTH);

  // Pick the earlier head for merge; ties go to the second queue
  assign pick_second = (cnt_q[0] == '0) ||
                       ((cnt_q[1] != '0) && !later(rd1_q.recv, rd0_q.recv));
  assign pick        = pick_second ? rd1_q : rd0_q;

  assign avg_sum = (AVW+1)'(avg_q) + ((AVW+1)'(res_life) << AVG_FRACTION_BITS);

  // Status toward the controller
  assign sts_o.walk     = (mode_q == MODE_MERGE) && !ovf && (tot_cnt != '0);
  assign sts_o.mrg_last = tot_cnt == (CW+1)'(1);
  assign sts_o.cpy_last = (i_q + CW'(1)) == n_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Next state of queue control and the result fields
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    oct_d       = oct_q;
    avg_d       = avg_q;
    n_d         = n_q;
    i_d         = i_q;
    res_status  = ST_OK;
    res_handle  = '0;
    res_octets  = '0;
    res_life    = '0;
    res_exp     = 1'b0;
    res_dropped = '0;
    rq          = sel_q;
    if (mode_q == MODE_DEQ && !empty_sel) begin
      res_life = now_q - deq_desc.recv;
    end
    if (cmd_i.accept) begin
      n_d = '0;
      i_d = '0;
    end
    if (cmd_i.mrg_step) begin
      n_d = n_q + CW'(1);
      if (pick_second) begin
        head_d[1] = wrap_inc(head_q[1]);
        cnt_d[1]  = cnt_q[1] - CW'(1);
      end else begin
        head_d[0] = wrap_inc(head_q[0]);
        cnt_d[0]  = cnt_q[0] - CW'(1);
      end
    end
    if (cmd_i.cpy_step) begin
      i_d = i_q + CW'(1);
    end
    if (cmd_i.commit) begin
      unique case (mode_q)
        MODE_ENQ: begin
          if (full_sel) begin
            res_status = ST_FULL;
          end else begin
            tail_d[sel_q] = wrap_inc(tail_q[sel_q]);
            cnt_d[sel_q]  = cnt_q[sel_q] + CW'(1);
            oct_d[sel_q]  = oct_q[sel_q] + OW'(octets_q);
          end
        end
        MODE_DEQ: begin
          if (empty_sel) begin
            res_status = ST_EMPTY;
          end else begin
            res_handle    = deq_desc.handle;
            res_octets    = deq_desc.octets;
            res_exp       = !deq_desc.inf && later(now_q, deq_desc.expiry);
            head_d[sel_q] = wrap_inc(head_q[sel_q]);
            cnt_d[sel_q]  = cnt_q[sel_q] - CW'(1);
            oct_d[sel_q]  = oct_q[sel_q] - OW'(deq_desc.octets);
            avg_d         = avg_sum[AVW:1];
          end
        end
        MODE_MERGE: begin
          rq = 1'b0;
          if (ovf) begin
            res_status = ST_FULL;
          end else begin
            head_d[0] = '0;
            tail_d[0] = (n_q == DEPTH_C) ? '0 : n_q[AW-1:0];
            cnt_d[0]  = n_q;
            oct_d[0]  = oct_q[0] + oct_q[1];
            head_d[1] = '0;
            tail_d[1] = '0;
            cnt_d[1]  = '0;
            oct_d[1]  = '0;
          end
        end
        MODE_CLEAR: begin
          res_dropped   = 7'(cnt_q[sel_q]);
          head_d[sel_q] = '0;
          tail_d[sel_q] = '0;
          cnt_d[sel_q]  = '0;
          oct_d[sel_q]  = '0;
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  // Latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_i;
      sel_q    <= sel_i;
      now_q    <= now_i;
      handle_q <= handle_i;
      octets_q <= octets_i;
      pdu_q    <= pdu_i;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forced_q    <= '0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      oct_q       <= '{default: '0};
      avg_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        forced_q <= cfg_data_i;
      end
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      oct_q  <= oct_d;
      avg_q  <= avg_d;
      n_q    <= n_d;
      i_q    <= i_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= res_status;
      handle_out_q <= res_handle;
      octets_out_q <= res_octets;
      life_q       <= (mode_q == MODE_DEQ && !empty_sel) ? res_life : 32'd0;
      exp_q        <= res_exp;
      count_q      <= 7'(rq ? cnt_d[1] : cnt_d[0]);
      qoct_q       <= 17'(rq ? oct_d[1] : oct_d[0]);
      avg_out_q    <= 32'(avg_d >> AVG_FRACTION_BITS);
      dropped_q    <= res_dropped;
    end
  end

  // First queue: enqueue or merge copy-back write, head read
  always_ff @(posedge clk_i) begin
    if (cmd_i.cpy_step) begin
      q0_mem[i_q[AW-1:0]] <= mbrd_q;
    end else if (cmd_i.commit && mode_q == MODE_ENQ && !full_sel && !sel_q) begin
      q0_mem[tail_q[0]] <= enq_desc;
    end
    rd0_q <= q0_mem[head_q[0]];
  end

  // Second queue: enqueue write, head read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mode_q == MODE_ENQ && !full_sel && sel_q) begin
      q1_mem[tail_q[1]] <= enq_desc;
    end
    rd1_q <= q1_mem[head_q[1]];
  end

  // Merge buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.mrg_step) begin
      mb_mem[n_q[AW-1:0]] <= pick;
    end
    mbrd_q <= mb_mem[i_q[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign handle_o    = handle_out_q;
  assign octets_o    = octets_out_q;
  assign life_o      = life_q;
  assign expired_o   = exp_q;
  assign count_o     = count_q;
  assign qoctets_o   = qoct_q;
  assign avg_o       = avg_out_q;
  assign dropped_o   = dropped_q;

endmodule

>>> rtl/core/frame_descriptor_queue_merge.sv
// Two FIFO queues of timestamped frame descriptors with merge by receive time.
// Top level: joins fdqm_ctrl and fdqm_dpath; uses fdqm_pkg.
//
// One word is taken at a time. Enqueue, dequeue and clear are accepted in
// the idle state and commit from the execute state, where the result word
// loads. A merge that moves n = count0 + count1 entries passes through the
// execute state, then per entry through the registered head reads of both
// queue memories into a merge buffer, then per entry copies the buffer
// back into the first queue, then a finishing state that loads its result.
// A merge that overflows or finds both queues empty commits from the
// execute state like the other operations. The result register lets the
// next word be accepted while a result waits; a full result register with
// the sink stalled holds the commit in the execute or finishing state. The
// configuration channel is always ready and sets the forced lifetime in
// centiseconds.
module frame_descriptor_queue_merge #(
  parameter int unsigned QUEUE_DEPTH       = fdqm_pkg::QueueDepthDef,
  parameter int unsigned AVG_FRACTION_BITS = fdqm_pkg::AvgFracDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // now_ms[31:0], frame_handle[43:32], frame_octets[54:44], delay_csec[70:55]
  input  logic [71:0]  s_axis_tdata_i,
  // mode[1:0], queue_sel[2]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_handle[11:0], out_octets[22:12], lifetime_ms[54:23], expired[55],
  // queue_count[62:56], octet_total[79:63], avg_delay_ms[111:80],
  // dropped_count[118:112]
  output logic [119:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);
  import fdqm_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [11:0] handle;
  logic [10:0] octets;
  logic [31:0] life;
  logic        expired;
  logic [6:0]  count;
  logic [16:0] qoctets;
  logic [31:0] avg;
  logic [6:0]  dropped;

  assign cfg_ready_o = 1'b1;

  fdqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdqm_dpath #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .AVG_FRACTION_BITS (AVG_FRACTION_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (s_axis_tuser_i[1:0]),
    .sel_i       (s_axis_tuser_i[2]),
    .now_i       (s_axis_tdata_i[31:0]),
    .handle_i    (s_axis_tdata_i[43:32]),
    .octets_i    (s_axis_tdata_i[54:44]),
    .pdu_i       (s_axis_tdata_i[70:55]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .status_o    (m_axis_tuser_o),
    .handle_o    (handle),
    .octets_o    (octets),
    .life_o      (life),
    .expired_o   (expired),
    .count_o     (count),
    .qoctets_o   (qoctets),
    .avg_o       (avg),
    .dropped_o   (dropped)
  );

  // Pack the result word
  assign m_axis_tdata_o = {1'b0, dropped, avg, qoctets, count, expired, life, octets, handle};

endmodule

>>> dv/testbench.sv
// Self-checking bench for frame_descriptor_queue_merge: random and directed words
// through the stream ports, checked against a queue-level predictor.
// Depends on fdqm_pkg and the frame_descriptor_queue_merge RTL.
module testbench;
  import fdqm_pkg::*;

  localparam int unsigned DEPTH = QueueDepthDef;
  localparam int unsigned FRAC  = AvgFracDef;
  localparam int unsigned AVW   = 32 + FRAC;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  user;
    logic [71:0] data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [119:0] data;
  } res_word_t;

  typedef struct {
    logic [11:0] handle;
    logic [10:0] octets;
    logic [31:0] recv;
    logic [31:0] expiry;
    logic        inf;
  } frame_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [71:0]  s_axis_tdata_i;
  logic [2:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [119:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i;

  frame_descriptor_queue_merge DUT (.*);

  // predictor state
  frame_t         fq [2][$];
  logic [16:0]    fq_octets [2] = '{default: '0};
  logic [AVW-1:0] avg_acc = '0;
  logic [15:0]    forced_csec;

  in_word_t  pending_words [$];
  res_word_t expected_results [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;
  int unsigned hold_cycles;
  bit          cfg_busy;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && !d[31];
  endfunction

  // Work out the result of one word and advance the queue model.
  function automatic res_word_t predict_queue_op(in_word_t w);
    res_word_t   r;
    logic [1:0]  mode;
    logic        sel;
    logic        rq;
    logic [31:0] now;
    logic [15:0] dly;
    logic [31:0] life;
    logic        exp;
    logic [6:0]  dropped;
    frame_t      f;
    frame_t      merged [$];
    mode = w.user[1:0];
    sel = w.user[2];
    rq = sel;
    now = w.data[31:0];
    life = 0;
    exp = 0;
    dropped = 0;
    f = '{default: '0};
    r.status = ST_OK;
    case (mode)
      MODE_ENQ: begin
        if (fq[sel].size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dly = (forced_csec != 0) ? forced_csec : w.data[70:55];
          f.handle = w.data[43:32];
          f.octets = w.data[54:44];
          f.recv = now;
          f.inf = (dly == INF_DELAY);
          f.expiry = f.inf ? 32'd0 : now + 32'(dly) * 32'd10;
          fq[sel].push_back(f);
          fq_octets[sel] += 17'(f.octets);
        end
      end
      MODE_DEQ: begin
        if (fq[sel].size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          f = fq[sel].pop_front();
          fq_octets[sel] -= 17'(f.octets);
          life = now - f.recv;
          exp = !f.inf && is_later(now, f.expiry);
          avg_acc = AVW'(((AVW+1)'(avg_acc) + ((AVW+1)'(life) << FRAC)) >> 1);
        end
        if (r.status != ST_OK) f = '{default: '0};
      end
      MODE_MERGE: begin
        rq = 1'b0;
        if (fq[0].size() + fq[1].size() > DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // second queue wins ties
          while (fq[0].size() != 0 || fq[1].size() != 0) begin
            if (fq[0].size() == 0) merged.push_back(fq[1].pop_front());
            else if (fq[1].size() == 0) merged.push_back(fq[0].pop_front());
            else if (is_later(fq[1][0].recv, fq[0][0].recv))
              merged.push_back(fq[0].pop_front());
            else merged.push_back(fq[1].pop_front());
          end
          fq[0] = merged;
          fq_octets[0] = fq_octets[0] + fq_octets[1];
          fq_octets[1] = 0;
        end
        f = '{default: '0};
      end
      default: begin
        dropped = 7'(fq[sel].size());
        fq[sel].delete();
        fq_octets[sel] = 0;
        f = '{default: '0};
      end
    endcase
    if (mode != MODE_DEQ) f = '{default: '0};
    r.data = {1'b0, dropped, avg_acc[FRAC +: 32], fq_octets[rq], 7'(fq[rq].size()),
              exp, life, f.octets, f.handle};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // driver: feed queued words, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      s_axis_tuser_i <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) expected_results.push_back(predict_queue_op(
          in_word_t'({s_axis_tuser_i, s_axis_tdata_i})));
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word_t w;
        w = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= w.data;
        s_axis_tuser_i <= w.user;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor: check each result word, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        res_word_t w;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", 128'(m_axis_tdata_o), 128'd0);
        end else begin
          w = expected_results.pop_front();
          if (m_axis_tuser_o !== w.status) report_mismatch("status", m_axis_tuser_o, w.status);
          if (m_axis_tdata_o[11:0] !== w.data[11:0])
            report_mismatch("out_handle", m_axis_tdata_o[11:0], w.data[11:0]);
          if (m_axis_tdata_o[22:12] !== w.data[22:12])
            report_mismatch("out_octets", m_axis_tdata_o[22:12], w.data[22:12]);
          if (m_axis_tdata_o[54:23] !== w.data[54:23])
            report_mismatch("lifetime_ms", m_axis_tdata_o[54:23], w.data[54:23]);
          if (m_axis_tdata_o[55] !== w.data[55])
            report_mismatch("expired", m_axis_tdata_o[55], w.data[55]);
          if (m_axis_tdata_o[62:56] !== w.data[62:56])
            report_mismatch("queue_count", m_axis_tdata_o[62:56], w.data[62:56]);
          if (m_axis_tdata_o[79:63] !== w.data[79:63])
            report_mismatch("octet_total", m_axis_tdata_o[79:63], w.data[79:63]);
          if (m_axis_tdata_o[111:80] !== w.data[111:80])
            report_mismatch("avg_delay_ms", m_axis_tdata_o[111:80], w.data[111:80]);
          if (m_axis_tdata_o[118:112] !== w.data[118:112])
            report_mismatch("dropped_count", m_axis_tdata_o[118:112], w.data[118:112]);
        end
        results_seen++;
      end
      // long hold-off while the sender keeps offering
      if (hold_off && hold_cycles < 400) begin
        hold_cycles <= hold_cycles + 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no accepted input word, result word or configuration write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_busy)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("watchdog: no progress, %0d results pending", expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(logic [1:0] mode, logic sel, logic [31:0] now,
                                         logic [11:0] h, logic [10:0] oct, logic [15:0] dly);
    in_word_t w;
    w.user = {sel, mode};
    w.data = {1'b0, dly, oct, h, now};
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_forced(logic [15:0] v);
    wait_drained();
    cfg_busy = 1'b1;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    forced_csec = v;
    cfg_busy = 1'b0;
  endtask

  // random traffic: mostly enqueue/dequeue with an advancing clock that at times jumps at random
  task automatic queue_random(int unsigned n, ref logic [31:0] now);
    int unsigned k;
    logic [1:0]  mode;
    logic [15:0] dly;
    for (k = 0; k < n; k++) begin
      now += $urandom_range(3) == 0 ? $urandom : $urandom_range(4000);
      case ($urandom_range(19))
        0: mode = MODE_MERGE;
        1: mode = MODE_CLEAR;
        2, 3, 4, 5, 6, 7, 8: mode = MODE_DEQ;
        default: mode = MODE_ENQ;
      endcase
      case ($urandom_range(3))
        0: dly = INF_DELAY;
        1: dly = 16'($urandom);
        default: dly = 16'($urandom_range(500));
      endcase
      pending_words.push_back(make_word(mode, 1'($urandom_range(1)), now, 12'($urandom),
                                        11'($urandom), dly));
    end
  endtask

  initial begin
    logic [31:0] now;
    int unsigned i;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    forced_csec = 0;
    hold_off = 1'b0;
    cfg_busy = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty dequeue, extremes, wrapped times, tie merge, clears
    pending_words.push_back(make_word(MODE_DEQ, 1'b0, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_MERGE, 1'b0, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_ENQ, 1'b0, 32'hffff_fff0, 12'hfff, 11'h7ff, 16'hfffe));
    pending_words.push_back(make_word(MODE_ENQ, 1'b1, 32'hffff_fff0, 12'h000, 11'h000, INF_DELAY));
    pending_words.push_back(make_word(MODE_ENQ, 1'b0, 32'h0000_0010, 12'h5a5, 11'h2aa, 16'd0));
    pending_words.push_back(make_word(MODE_ENQ, 1'b1, 32'h7fff_ffff, 12'ha5a, 11'h555, 16'd1));
    pending_words.push_back(make_word(MODE_MERGE, 1'b1, 32'h8000_0000, 0, 0, 0));
    pending_words.push_back(make_word(MODE_DEQ, 1'b0, 32'hffff_ffff, 0, 0, 0));
    pending_words.push_back(make_word(MODE_DEQ, 1'b0, 32'h0000_0020, 0, 0, 0));
    pending_words.push_back(make_word(MODE_DEQ, 1'b1, 32'h0000_0020, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b0, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b1, 0, 0, 0, 0));
    // fill both queues to depth: full enqueue and merge overflow
    for (i = 0; i < 2 * DEPTH + 2; i++)
      pending_words.push_back(make_word(MODE_ENQ, i[0], i * 7, i[11:0], 11'h7ff, 16'd3));
    pending_words.push_back(make_word(MODE_MERGE, 1'b0, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b1, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_MERGE, 1'b0, 0, 0, 0, 0));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b0, 0, 0, 0, 0));
    wait_drained();

    // the sender keeps offering random words through a long sink hold-off
    hold_off = 1'b1;
    now = 32'hffff_0000;
    queue_random(40, now);
    wait_drained();
    hold_off = 1'b0;

    write_forced(16'd1);
    queue_random(500, now);
    write_forced(INF_DELAY);
    send_idle_pct = 68;
    recv_idle_pct = 23;
    queue_random(500, now);
    write_forced(16'hfffe);
    queue_random(200, now);
    write_forced(16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(450, now);
    wait_drained();

    $display("covered %0d result words: enqueue, dequeue, merge and clear under",
             results_seen);
    $display("four forced-lifetime settings, full queues, overflow and sink hold-off");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fdqm_pkg.sv
rtl/core/fdqm_ctrl.sv
rtl/core/fdqm_dpath.sv
rtl/core/frame_descriptor_queue_merge.sv
dv/testbench.sv
